// ===== sv/gcet_pkg.sv =====
package gcet_pkg;

    localparam int TIME_W     = 48;
    localparam int DIV_STEP   = 2;
    localparam int DIV_STAGES = TIME_W / DIV_STEP;
    // input register, quotient stages, rounding register
    localparam int DIV_LAT    = DIV_STAGES + 2;
    localparam int FRONT_LAT  = 4;
    localparam int SEL_LAT    = 2;
    localparam int TOTAL_LAT  = FRONT_LAT + DIV_LAT + SEL_LAT;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;
    localparam logic [47:0]       POS_CAP  = 48'h8000_0000_0000;

    localparam logic [5:0] SIDE_PZ = 6'h01;
    localparam logic [5:0] SIDE_PX = 6'h02;
    localparam logic [5:0] SIDE_NY = 6'h04;
    localparam logic [5:0] SIDE_PY = 6'h08;
    localparam logic [5:0] SIDE_NX = 6'h10;
    localparam logic [5:0] SIDE_NZ = 6'h20;

    localparam logic [1:0] REG_SPACE_SIZE = 2'd0;

    typedef struct packed {
        logic [9:0]  cell_i;
        logic [9:0]  cell_j;
        logic [9:0]  cell_k;
        logic [3:0]  depth;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic [47:0] now_time;
        logic [47:0] last_hit_time;
    } gcet_in_t;

    typedef struct packed {
        logic [47:0] exit_time;
        logic        found;
        logic [5:0]  hit_sides;
        logic signed [11:0] next_i;
        logic signed [11:0] next_j;
        logic signed [11:0] next_k;
    } gcet_out_t;

    // per-axis status carried alongside the divider
    typedef struct packed {
        logic live;
        logic zero;
        logic fwd;
        logic vneg;
    } gcet_flags_t;

    typedef struct packed {
        logic [47:0] now_time;
        logic [9:0]  cell_i;
        logic [9:0]  cell_j;
        logic [9:0]  cell_k;
    } gcet_tag_t;

    // side facing the velocity on an axis (0 x, 1 y, 2 z)
    function automatic logic [5:0] side_mask(input logic [1:0] axis, input logic vneg);
        logic [5:0] m;
        begin
            case (axis)
                2'd0:    m = vneg ? SIDE_NX : SIDE_PX;
                2'd1:    m = vneg ? SIDE_NY : SIDE_PY;
                2'd2:    m = vneg ? SIDE_NZ : SIDE_PZ;
                default: m = '0;
            endcase
            return m;
        end
    endfunction

    // visiting order of that side
    function automatic logic [2:0] side_rank(input logic [1:0] axis, input logic vneg);
        logic [2:0] r;
        begin
            case (axis)
                2'd0:    r = vneg ? 3'd4 : 3'd1;
                2'd1:    r = vneg ? 3'd2 : 3'd3;
                2'd2:    r = vneg ? 3'd5 : 3'd0;
                default: r = 3'd7;
            endcase
            return r;
        end
    endfunction

endpackage

// ===== sv/gcet_front.sv =====
module gcet_front #(
    parameter int MAX_DEPTH = 10,
    parameter int FRAC_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  gcet_pkg::gcet_in_t  item,
    input  logic [30:0]         space_size,
    output logic                out_valid,
    output logic [48:0]         ad [3],
    output logic [31:0]         av [3],
    output gcet_pkg::gcet_flags_t flags [3],
    output gcet_pkg::gcet_tag_t tag
);
    import gcet_pkg::*;

    localparam logic signed [49:0] PCAP = 50'sd140737488355328;

    // stage 1
    logic [48:0] diff, ndiff;
    logic [47:0] adiff;
    logic [3:0]  dep;
    logic [30:0] cs;
    logic signed [31:0] vel [3];
    logic signed [31:0] pos [3];
    logic [9:0]  cidx [3];
    logic [32:0] nv [3];
    logic [10:0] idx [3];

    logic        v1_reg;
    logic [47:0] adiff1_reg;
    logic        dneg1_reg;
    logic [31:0] av1_reg [3];
    logic        vneg1_reg [3];
    logic        vzero1_reg [3];
    logic signed [31:0] pos1_reg [3];
    logic [41:0] wall1_reg [3];
    gcet_tag_t   tag1_reg;

    always_comb
    begin
        diff  = {1'b0, item.now_time} - {1'b0, item.last_hit_time};
        ndiff = -diff;
        adiff = diff[48] ? ndiff[47:0] : diff[47:0];
        dep   = ({28'd0, item.depth} > MAX_DEPTH) ? 4'(MAX_DEPTH) : item.depth;
        cs    = space_size >> dep;
        vel[0] = item.vel_x;  vel[1] = item.vel_y;  vel[2] = item.vel_z;
        pos[0] = item.pos_x;  pos[1] = item.pos_y;  pos[2] = item.pos_z;
        cidx[0] = item.cell_i; cidx[1] = item.cell_j; cidx[2] = item.cell_k;
        for (int a = 0; a < 3; a++)
        begin
            nv[a]  = -{vel[a][31], vel[a]};
            idx[a] = {1'b0, cidx[a]} + {10'd0, ~vel[a][31]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        adiff1_reg <= adiff;
        dneg1_reg  <= diff[48];
        tag1_reg   <= '{now_time: item.now_time, cell_i: item.cell_i,
                        cell_j: item.cell_j, cell_k: item.cell_k};
        for (int a = 0; a < 3; a++)
        begin
            av1_reg[a]    <= vel[a][31] ? nv[a][31:0] : vel[a];
            vneg1_reg[a]  <= vel[a][31];
            vzero1_reg[a] <= (vel[a] == 32'sd0);
            pos1_reg[a]   <= pos[a];
            wall1_reg[a]  <= 42'(idx[a]) * 42'(cs);
        end
    end

    // stage 2: split product of speed and elapsed time
    logic        v2_reg;
    logic [55:0] plo2_reg [3];
    logic [55:0] phi2_reg [3];
    logic        sub2_reg [3];
    logic        vneg2_reg [3];
    logic        vzero2_reg [3];
    logic [31:0] av2_reg [3];
    logic signed [31:0] pos2_reg [3];
    logic [41:0] wall2_reg [3];
    gcet_tag_t   tag2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        tag2_reg <= tag1_reg;
        for (int a = 0; a < 3; a++)
        begin
            plo2_reg[a]   <= 56'(av1_reg[a]) * 56'(adiff1_reg[23:0]);
            phi2_reg[a]   <= 56'(av1_reg[a]) * 56'(adiff1_reg[47:24]);
            sub2_reg[a]   <= vneg1_reg[a] ^ dneg1_reg;
            vneg2_reg[a]  <= vneg1_reg[a];
            vzero2_reg[a] <= vzero1_reg[a];
            av2_reg[a]    <= av1_reg[a];
            pos2_reg[a]   <= pos1_reg[a];
            wall2_reg[a]  <= wall1_reg[a];
        end
    end

    // stage 3: advanced position
    logic [80:0] full [3];
    logic [80:0] shr [3];
    logic [47:0] mv [3];
    logic signed [49:0] p [3];
    logic signed [49:0] pc [3];

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            full[a] = 81'({phi2_reg[a], 24'd0}) + 81'(plo2_reg[a]);
            shr[a]  = full[a] >> FRAC_BITS;
            mv[a]   = (shr[a] > 81'(POS_CAP)) ? POS_CAP : shr[a][47:0];
            if (sub2_reg[a])
            begin
                p[a] = {{18{pos2_reg[a][31]}}, pos2_reg[a]} - signed'({2'b00, mv[a]});
            end
            else
            begin
                p[a] = {{18{pos2_reg[a][31]}}, pos2_reg[a]} + signed'({2'b00, mv[a]});
            end
            if (p[a] > PCAP)
            begin
                pc[a] = PCAP;
            end
            else if (p[a] < -PCAP)
            begin
                pc[a] = -PCAP;
            end
            else
            begin
                pc[a] = p[a];
            end
        end
    end

    logic        v3_reg;
    logic signed [48:0] cpos3_reg [3];
    logic        vneg3_reg [3];
    logic        vzero3_reg [3];
    logic [31:0] av3_reg [3];
    logic [41:0] wall3_reg [3];
    gcet_tag_t   tag3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        tag3_reg <= tag2_reg;
        for (int a = 0; a < 3; a++)
        begin
            cpos3_reg[a]  <= pc[a][48:0];
            vneg3_reg[a]  <= vneg2_reg[a];
            vzero3_reg[a] <= vzero2_reg[a];
            av3_reg[a]    <= av2_reg[a];
            wall3_reg[a]  <= wall2_reg[a];
        end
    end

    // stage 4: distance to the wall ahead
    logic signed [49:0] d [3];
    logic signed [49:0] nd [3];

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            d[a]  = signed'({8'd0, wall3_reg[a]}) - {cpos3_reg[a][48], cpos3_reg[a]};
            nd[a] = -d[a];
        end
    end

    logic        v4_reg;
    logic [48:0] ad4_reg [3];
    logic [31:0] av4_reg [3];
    gcet_flags_t fl4_reg [3];
    gcet_tag_t   tag4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
        end
        else
        begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        tag4_reg <= tag3_reg;
        for (int a = 0; a < 3; a++)
        begin
            ad4_reg[a] <= d[a][49] ? nd[a][48:0] : d[a][48:0];
            av4_reg[a] <= av3_reg[a];
            fl4_reg[a] <= '{live: ~vzero3_reg[a],
                            zero: (d[a] == 50'sd0),
                            fwd:  (d[a] != 50'sd0) && (d[a][49] == vneg3_reg[a]),
                            vneg: vneg3_reg[a]};
        end
    end

    assign out_valid = v4_reg;
    assign ad        = ad4_reg;
    assign av        = av4_reg;
    assign flags     = fl4_reg;
    assign tag       = tag4_reg;

endmodule

// ===== sv/gcet_div.sv =====
module gcet_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic        clk,
    input  logic [48:0] ad,
    input  logic [31:0] av,
    output logic [47:0] t
);
    import gcet_pkg::*;

    // ceil(ad * 2^frac / av), saturated; DIV_STEP quotient bits per stage
    logic [48:0] hi;
    logic        sat0;

    logic [31:0]       rem_reg [DIV_STAGES+1];
    logic [TIME_W-1:0] num_reg [DIV_STAGES+1];
    logic [TIME_W-1:0] quo_reg [DIV_STAGES+1];
    logic              sat_reg [DIV_STAGES+1];
    logic [31:0]       den_reg [DIV_STAGES+1];
    logic [TIME_W-1:0] t_reg;

    always_comb
    begin
        hi   = ad >> (TIME_W - FRAC_BITS);
        sat0 = hi >= {17'd0, av};
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= hi[31:0];
        num_reg[0] <= TIME_W'(ad[47:0] << FRAC_BITS);
        quo_reg[0] <= '0;
        sat_reg[0] <= sat0;
        den_reg[0] <= av;
    end

    for (genvar s = 1; s <= DIV_STAGES; s++)
    begin : g_stage
        logic [31:0]       r;
        logic [32:0]       r33;
        logic [TIME_W-1:0] n;
        logic [TIME_W-1:0] q;

        always_comb
        begin
            r   = rem_reg[s-1];
            n   = num_reg[s-1];
            q   = quo_reg[s-1];
            r33 = '0;
            for (int k = 0; k < DIV_STEP; k++)
            begin
                r33 = {r, n[TIME_W-1]};
                n   = n << 1;
                if (r33 >= {1'b0, den_reg[s-1]})
                begin
                    r33 = r33 - {1'b0, den_reg[s-1]};
                    q   = {q[TIME_W-2:0], 1'b1};
                end
                else
                begin
                    q   = {q[TIME_W-2:0], 1'b0};
                end
                r = r33[31:0];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[s] <= r;
            num_reg[s] <= n;
            quo_reg[s] <= q;
            sat_reg[s] <= sat_reg[s-1];
            den_reg[s] <= den_reg[s-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (sat_reg[DIV_STAGES])
        begin
            t_reg <= TIME_MAX;
        end
        else if (rem_reg[DIV_STAGES] != 32'd0)
        begin
            t_reg <= (quo_reg[DIV_STAGES] == TIME_MAX) ? TIME_MAX
                                                         : quo_reg[DIV_STAGES] + 1'b1;
        end
        else
        begin
            t_reg <= quo_reg[DIV_STAGES];
        end
    end

    assign t = t_reg;

endmodule

// ===== sv/gcet_select.sv =====
module gcet_select (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic [47:0]           t [3],
    input  gcet_pkg::gcet_flags_t flags [3],
    input  gcet_pkg::gcet_tag_t   tag,
    output logic                  out_valid,
    output gcet_pkg::gcet_out_t   result
);
    import gcet_pkg::*;

    // stage a: which axes compete, pairwise compares
    logic [2:0] rank [3];
    logic [2:0] zrank;
    logic       anyz;
    logic [5:0] zmask;
    logic [2:0] cand;

    always_comb
    begin
        zrank = 3'd7;
        zmask = '0;
        anyz  = 1'b0;
        for (int a = 0; a < 3; a++)
        begin
            rank[a] = side_rank(2'(a), flags[a].vneg);
        end
        // first zero distance in visiting order ends the search
        for (int a = 0; a < 3; a++)
        begin
            if (flags[a].live && flags[a].zero && rank[a] < zrank)
            begin
                zrank = rank[a];
                zmask = side_mask(2'(a), flags[a].vneg);
                anyz  = 1'b1;
            end
        end
        for (int a = 0; a < 3; a++)
        begin
            cand[a] = flags[a].live && flags[a].fwd && (rank[a] < zrank);
        end
    end

    logic        va_reg;
    logic [2:0]  cand_reg;
    logic        anyz_reg;
    logic [5:0]  zmask_reg;
    logic        lt_reg [3][3];
    logic [47:0] t_reg [3];
    logic        vneg_reg [3];
    gcet_tag_t   tag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
        end
        else
        begin
            va_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        cand_reg  <= cand;
        anyz_reg  <= anyz;
        zmask_reg <= zmask;
        tag_reg   <= tag;
        for (int a = 0; a < 3; a++)
        begin
            t_reg[a]    <= t[a];
            vneg_reg[a] <= flags[a].vneg;
            for (int b = 0; b < 3; b++)
            begin
                lt_reg[a][b] <= t[a] < t[b];
            end
        end
    end

    // stage b: winners, exit time, neighbor
    logic [2:0]  hit;
    logic        have;
    logic [47:0] best;
    logic [48:0] sum;
    logic [5:0]  mask;
    gcet_out_t   res;

    always_comb
    begin
        mask = zmask_reg;
        for (int a = 0; a < 3; a++)
        begin
            hit[a] = cand_reg[a];
            for (int b = 0; b < 3; b++)
            begin
                if (b != a && cand_reg[b] && lt_reg[b][a])
                begin
                    hit[a] = 1'b0;
                end
            end
            if (hit[a])
            begin
                mask = mask | side_mask(2'(a), vneg_reg[a]);
            end
        end
        have = |cand_reg;
        best = hit[0] ? t_reg[0] : (hit[1] ? t_reg[1] : t_reg[2]);
        sum  = {1'b0, tag_reg.now_time} + {1'b0, best};
        if (anyz_reg)
        begin
            res.exit_time = tag_reg.now_time;
        end
        else if (have)
        begin
            res.exit_time = sum[48] ? TIME_MAX : sum[47:0];
        end
        else
        begin
            res.exit_time = '0;
        end
        res.found     = anyz_reg | have;
        res.hit_sides = mask;
        res.next_i = signed'({2'b00, tag_reg.cell_i})
                   + ((mask & SIDE_PX) != 0 ? 12'sd1 : ((mask & SIDE_NX) != 0 ? -12'sd1 : 12'sd0));
        res.next_j = signed'({2'b00, tag_reg.cell_j})
                   + ((mask & SIDE_PY) != 0 ? 12'sd1 : ((mask & SIDE_NY) != 0 ? -12'sd1 : 12'sd0));
        res.next_k = signed'({2'b00, tag_reg.cell_k})
                   + ((mask & SIDE_PZ) != 0 ? 12'sd1 : ((mask & SIDE_NZ) != 0 ? -12'sd1 : 12'sd0));
    end

    logic      vb_reg;
    gcet_out_t res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vb_reg <= 1'b0;
        end
        else
        begin
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res;
    end

    assign out_valid = vb_reg;
    assign result    = res_reg;

endmodule

// ===== sv/grid_cell_exit_time_unit.sv =====
// channel   | handshake            | payload
// ----------+----------------------+-----------------------------
// item in   | start, busy          | item   (gcet_in_t)
// result    | done (one cycle)     | result (gcet_out_t)
// config    | psel/penable/pwrite  | paddr, pwdata, prdata
//
// one item per cycle; results return in the order of their start beats
// latency is mostly in the three long dividers, 2 quotient bits per stage
// busy is tied low: the pipeline never holds, results cannot be stalled
// reset clears valid bits and sets space_size to 1000.0
module grid_cell_exit_time_unit #(
    parameter int MAX_DEPTH = 10,
    parameter int FRAC_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  gcet_pkg::gcet_in_t  item,
    output logic                done,
    output gcet_pkg::gcet_out_t result,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import gcet_pkg::*;

    logic [30:0] space_size_reg;

    assign pready = 1'b1;
    assign busy   = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            space_size_reg <= 31'd65536000;
        end
        else if (psel && penable && pwrite && pready && paddr[2] == REG_SPACE_SIZE[0])
        begin
            space_size_reg <= pwdata[30:0];
        end
    end

    assign prdata = (paddr[2] == REG_SPACE_SIZE[0]) ? {1'b0, space_size_reg} : 32'd0;

    logic        f_valid;
    logic [48:0] f_ad [3];
    logic [31:0] f_av [3];
    gcet_flags_t f_flags [3];
    gcet_tag_t   f_tag;

    gcet_front #(
        .MAX_DEPTH (MAX_DEPTH),
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (start && !busy),
        .item       (item),
        .space_size (space_size_reg),
        .out_valid  (f_valid),
        .ad         (f_ad),
        .av         (f_av),
        .flags      (f_flags),
        .tag        (f_tag)
    );

    logic [47:0] d_t [3];

    for (genvar a = 0; a < 3; a++)
    begin : g_axis
        gcet_div #(
            .FRAC_BITS (FRAC_BITS)
        ) u_div (
            .clk (clk),
            .ad  (f_ad[a]),
            .av  (f_av[a]),
            .t   (d_t[a])
        );
    end

    // side info rides along the divider latency
    logic        dl_valid_reg [DIV_LAT];
    gcet_flags_t dl_flags_reg [DIV_LAT][3];
    gcet_tag_t   dl_tag_reg [DIV_LAT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIV_LAT; i++)
            begin
                dl_valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            dl_valid_reg[0] <= f_valid;
            for (int i = 1; i < DIV_LAT; i++)
            begin
                dl_valid_reg[i] <= dl_valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dl_flags_reg[0] <= f_flags;
        dl_tag_reg[0]   <= f_tag;
        for (int i = 1; i < DIV_LAT; i++)
        begin
            dl_flags_reg[i] <= dl_flags_reg[i-1];
            dl_tag_reg[i]   <= dl_tag_reg[i-1];
        end
    end

    gcet_select u_select (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dl_valid_reg[DIV_LAT-1]),
        .t         (d_t),
        .flags     (dl_flags_reg[DIV_LAT-1]),
        .tag       (dl_tag_reg[DIV_LAT-1]),
        .out_valid (done),
        .result    (result)
    );

    a_none_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.found |-> result.exit_time == 48'd0 && result.hit_sides == 6'd0)
        else $error("no crossing but nonzero time or sides");

    a_found_has_side: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.found |-> result.hit_sides != 6'd0)
        else $error("crossing found with no side marked");

    a_one_side_x: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(result.hit_sides[1] && result.hit_sides[4]))
        else $error("both x sides marked");

endmodule

// ===== sim/grid_cell_exit_time_unit_tb.sv =====
module grid_cell_exit_time_unit_tb;
    import gcet_pkg::*;

    localparam int MAX_DEPTH_TB = 10;
    localparam int FRAC = 16;
    localparam int LAT = 32;
    localparam logic [63:0] CAP = 64'h0000_8000_0000_0000;
    localparam logic [47:0] TMAX = 48'hFFFF_FFFF_FFFF;

    typedef struct {
        gcet_in_t  stim;
        logic      has_exp;
        gcet_out_t exp;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    gcet_in_t    item;
    logic        done;
    gcet_out_t   result;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    logic [30:0] cube_edge;
    gcet_out_t   exit_q[$];
    gcet_out_t   typed_q[$];
    logic        typed_flag_q[$];
    int          errors;
    dir_row_t    dir_rows[$];

    grid_cell_exit_time_unit dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .done(done), .result(result), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50000000;
        $display("FAIL grid_cell_exit_time_unit");
        $finish;
    end

    // |v| * |dt| >> FRAC, saturated at the position cap
    function automatic logic [63:0] move_amount(input logic [63:0] v, input logic [63:0] dt);
        logic [127:0] p;
        begin
            p = (128'(v) * 128'(dt)) >> FRAC;
            return (p > 128'(CAP)) ? CAP : p[63:0];
        end
    endfunction

    function automatic logic [47:0] cross_time(input logic [63:0] d, input logic [63:0] v);
        logic [127:0] num;
        logic [127:0] q;
        begin
            num = 128'(d) << FRAC;
            q = num / 128'(v);
            if (num % 128'(v) != 0)
                q = q + 1;
            return (q > 128'(TMAX)) ? TMAX : q[47:0];
        end
    endfunction

    function automatic gcet_out_t predict_exit(input gcet_in_t x, input logic [30:0] edge_len);
        logic signed [63:0] cidx[3];
        logic signed [63:0] pos[3];
        logic signed [63:0] vel[3];
        logic signed [63:0] cpos[3];
        logic signed [63:0] nxt[3];
        logic signed [63:0] diff;
        logic signed [63:0] wall;
        logic signed [63:0] d;
        logic [63:0] adiff;
        logic [63:0] av;
        logic [63:0] m;
        logic [63:0] cs;
        logic [63:0] e;
        logic [47:0] best;
        logic [47:0] t;
        logic [5:0] hits;
        logic [5:0] bitm;
        logic [3:0] dep;
        logic zero;
        logic have;
        logic up;
        int ax;
        gcet_out_t r;
        begin
            cidx[0] = 64'(x.cell_i); cidx[1] = 64'(x.cell_j); cidx[2] = 64'(x.cell_k);
            pos[0] = 64'(x.pos_x); pos[1] = 64'(x.pos_y); pos[2] = 64'(x.pos_z);
            vel[0] = 64'(x.vel_x); vel[1] = 64'(x.vel_y); vel[2] = 64'(x.vel_z);
            diff = $signed({16'd0, x.now_time}) - $signed({16'd0, x.last_hit_time});
            adiff = diff < 0 ? -diff : diff;
            dep = x.depth > MAX_DEPTH_TB ? 4'(MAX_DEPTH_TB) : x.depth;
            cs = 64'(edge_len) >> dep;
            for (int a = 0; a < 3; a++)
            begin
                av = vel[a] < 0 ? -vel[a] : vel[a];
                m = move_amount(av, adiff);
                cpos[a] = ((vel[a] < 0) != (diff < 0)) ? pos[a] - $signed(m)
                                                       : pos[a] + $signed(m);
                if (cpos[a] > $signed(CAP))
                    cpos[a] = CAP;
                if (cpos[a] < -$signed(CAP))
                    cpos[a] = -$signed(CAP);
            end
            hits = '0; best = '0; zero = 1'b0; have = 1'b0;
            for (int s = 0; s < 6; s++)
            begin
                if (zero)
                    continue;
                case (s)
                    0: begin ax = 2; up = 1'b1; bitm = SIDE_PZ; end
                    1: begin ax = 0; up = 1'b1; bitm = SIDE_PX; end
                    2: begin ax = 1; up = 1'b0; bitm = SIDE_NY; end
                    3: begin ax = 1; up = 1'b1; bitm = SIDE_PY; end
                    4: begin ax = 0; up = 1'b0; bitm = SIDE_NX; end
                    default: begin ax = 2; up = 1'b0; bitm = SIDE_NZ; end
                endcase
                if (vel[ax] == 0 || (up ? vel[ax] < 0 : vel[ax] > 0))
                    continue;
                wall = (cidx[ax] + (up ? 64'sd1 : 64'sd0)) * $signed(cs);
                d = wall - cpos[ax];
                if (d == 0)
                begin
                    zero = 1'b1;
                    hits |= bitm;
                    continue;
                end
                if ((d > 0) != (vel[ax] > 0))
                    continue;
                av = vel[ax] < 0 ? -vel[ax] : vel[ax];
                t = cross_time(d < 0 ? -d : d, av);
                if (!have)
                begin
                    best = t; hits |= bitm; have = 1'b1;
                end
                else if (t < best)
                begin
                    best = t; hits = bitm;
                end
                else if (t == best)
                    hits |= bitm;
            end
            e = 64'(x.now_time) + 64'(best);
            r.exit_time = zero ? x.now_time : (have ? (e > 64'(TMAX) ? TMAX : e[47:0]) : '0);
            r.found = zero | have;
            r.hit_sides = hits;
            nxt[0] = cidx[0]; nxt[1] = cidx[1]; nxt[2] = cidx[2];
            if (hits & SIDE_PZ) nxt[2] = cidx[2] + 1;
            if (hits & SIDE_PX) nxt[0] = cidx[0] + 1;
            if (hits & SIDE_NY) nxt[1] = cidx[1] - 1;
            if (hits & SIDE_PY) nxt[1] = cidx[1] + 1;
            if (hits & SIDE_NX) nxt[0] = cidx[0] - 1;
            if (hits & SIDE_NZ) nxt[2] = cidx[2] - 1;
            r.next_i = nxt[0][11:0]; r.next_j = nxt[1][11:0]; r.next_k = nxt[2][11:0];
            return r;
        end
    endfunction

    function automatic gcet_in_t rand_particle();
        gcet_in_t x;
        logic [47:0] dt;
        begin
            x.cell_i = 10'($urandom); x.cell_j = 10'($urandom); x.cell_k = 10'($urandom);
            x.depth = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(0, 10));
            x.pos_x = $urandom; x.pos_y = $urandom; x.pos_z = $urandom;
            x.vel_x = $urandom; x.vel_y = $urandom; x.vel_z = $urandom;
            case ($urandom_range(0, 3))
                0: begin x.vel_x = 0; x.vel_y = $signed(32'($urandom_range(0, 4))) - 2; end
                1: begin x.vel_z = $signed(32'($urandom_range(0, 200000))) - 100000; end
                default: ;
            endcase
            // keep particles mostly inside the cube so walls are near
            if ($urandom_range(0, 3) != 0)
            begin
                x.pos_x = $urandom_range(0, 32'(cube_edge));
                x.pos_y = $urandom_range(0, 32'(cube_edge));
                x.pos_z = $urandom_range(0, 32'(cube_edge));
                x.cell_i = 10'($urandom_range(0, 1023) & ((1 << x.depth) - 1));
            end
            x.now_time = 48'({$urandom, $urandom});
            dt = $urandom_range(0, 3) == 0 ? 48'({$urandom, $urandom})
                                           : 48'($urandom_range(0, 200000));
            x.last_hit_time = ($urandom_range(0, 7) == 0) ? x.now_time + dt[15:0]
                                                         : x.now_time - dt;
            return x;
        end
    endfunction

    task automatic reg_write(input logic [30:0] val);
        begin
            @(posedge clk);
            psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
            paddr <= 3'({REG_SPACE_SIZE, 2'b00}); pwdata <= {1'b0, val};
            @(posedge clk);
            penable <= 1'b1;
            @(posedge clk);
            psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
            cube_edge = val;
        end
    endtask

    task automatic send_particle(input gcet_in_t x, input logic has_exp, input gcet_out_t ex);
        begin
            @(posedge clk);
            start <= 1'b1;
            item <= x;
            exit_q.push_back(predict_exit(x, cube_edge));
            typed_flag_q.push_back(has_exp);
            typed_q.push_back(ex);
            while (busy)
                @(posedge clk);
        end
    endtask

    task automatic drain();
        begin
            @(posedge clk);
            start <= 1'b0;
            while (exit_q.size() != 0)
                @(posedge clk);
            repeat (LAT + 4) @(posedge clk);
        end
    endtask

    task automatic random_burst(input int count);
        int left;
        begin
            left = count;
            while (left > 0)
            begin
                for (int b = $urandom_range(1, 20); b > 0 && left > 0; b--)
                begin
                    send_particle(rand_particle(), 1'b0, '0);
                    left--;
                end
                @(posedge clk);
                start <= 1'b0;
                if ($urandom_range(0, 2) != 0)
                    repeat ($urandom_range(0, 12)) @(posedge clk);
            end
        end
    endtask

    // result checker: every done beat is taken
    always @(posedge clk)
    begin
        gcet_out_t ex;
        gcet_out_t ty;
        logic tf;
        if (rst_n && done)
        begin
            if (exit_q.size() == 0)
            begin
                $display("%0t unexpected beat %p", $time, result);
                errors++;
            end
            else
            begin
                ex = exit_q.pop_front();
                tf = typed_flag_q.pop_front();
                ty = typed_q.pop_front();
                if (tf && ty !== ex)
                begin
                    $display("%0t table row expected %p predictor %p", $time, ty, ex);
                    errors++;
                end
                if (result.exit_time !== ex.exit_time || result.found !== ex.found ||
                    result.hit_sides !== ex.hit_sides || result.next_i !== ex.next_i ||
                    result.next_j !== ex.next_j || result.next_k !== ex.next_k)
                begin
                    $display("%0t mismatch expected %p actual %p", $time, ex, result);
                    errors++;
                end
            end
        end
    end

    function automatic gcet_in_t mk(input logic [9:0] ci, input logic [9:0] cj,
                                    input logic [9:0] ck, input logic [3:0] dp,
                                    input logic [31:0] px, input logic [31:0] py,
                                    input logic [31:0] pz, input logic [31:0] vx,
                                    input logic [31:0] vy, input logic [31:0] vz,
                                    input logic [47:0] nt, input logic [47:0] lt);
        gcet_in_t x;
        begin
            x.cell_i = ci; x.cell_j = cj; x.cell_k = ck; x.depth = dp;
            x.pos_x = px; x.pos_y = py; x.pos_z = pz;
            x.vel_x = vx; x.vel_y = vy; x.vel_z = vz;
            x.now_time = nt; x.last_hit_time = lt;
            return x;
        end
    endfunction

    function automatic gcet_out_t mko(input logic [47:0] et, input logic f, input logic [5:0] hs,
                                      input logic [11:0] ni, input logic [11:0] nj,
                                      input logic [11:0] nk);
        gcet_out_t r;
        begin
            r.exit_time = et; r.found = f; r.hit_sides = hs;
            r.next_i = ni; r.next_j = nj; r.next_k = nk;
            return r;
        end
    endfunction

    task automatic add_row(input gcet_in_t x, input logic he, input gcet_out_t ex);
        dir_row_t r;
        begin
            r.stim = x; r.has_exp = he; r.exp = ex;
            dir_rows.push_back(r);
        end
    endtask

    initial
    begin
        errors = 0;
        cube_edge = 31'd65536000;
        rst_n = 1'b0; start = 1'b0; item = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;

        // zero velocity: no crossing
        add_row(mk(10'd5, 10'd6, 10'd7, 4'd3, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
                   48'd100, 48'd0), 1'b1, mko(48'd0, 1'b0, 6'd0, 12'd5, 12'd6, 12'd7));
        // at the low wall moving down: stops at now
        add_row(mk(10'd0, 10'd0, 10'd0, 4'd0, 32'd0, 32'd0, 32'd0, -32'sd65536, 32'd0, 32'd0,
                   48'd777, 48'd777), 1'b1,
                mko(48'd777, 1'b1, SIDE_NX, -12'sd1, 12'd0, 12'd0));
        // unit velocity, one cell edge (64000) from the +x wall at depth 10
        add_row(mk(10'd0, 10'd0, 10'd0, 4'd10, 32'd0, 32'd0, 32'd0, 32'd65536, 32'd0, 32'd0,
                   48'd0, 48'd0), 1'b0, '0);
        // diagonal tie on all three up walls
        add_row(mk(10'd1, 10'd1, 10'd1, 4'd1, 32'd0, 32'd0, 32'd0, 32'd65536, 32'd65536,
                   32'd65536, 48'd0, 48'd0), 1'b0, '0);
        // index edge at top
        add_row(mk(10'd1023, 10'd1023, 10'd1023, 4'd10, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                   32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 48'hFFFFFFFFFFFF, 48'd0), 1'b0, '0);
        // extremes of velocity and position
        add_row(mk(10'd0, 10'd0, 10'd0, 4'd15, 32'h80000000, 32'h80000000, 32'h80000000,
                   32'h80000000, 32'h80000000, 32'h80000000, 48'd0, 48'hFFFFFFFFFFFF), 1'b0, '0);
        // slowest velocity: saturated ties
        add_row(mk(10'd3, 10'd3, 10'd3, 4'd0, 32'h80000000, 32'h80000000, 32'h80000000,
                   32'd1, 32'd1, 32'd1, 48'hFFFFFFFF0000, 48'hFFFFFFFF0000), 1'b0, '0);
        // wall behind: position past the +x wall
        add_row(mk(10'd0, 10'd2, 10'd2, 4'd4, 32'h7FFFFFFF, 32'd0, 32'd0, 32'd100, 32'd0, 32'd0,
                   48'd5, 48'd5), 1'b0, '0);
        // last hit after now
        add_row(mk(10'd4, 10'd4, 10'd4, 4'd5, 32'd1000000, 32'd2000000, 32'd3000000,
                   -32'sd300, 32'd500, -32'sd7000, 48'd1000, 48'd90000), 1'b0, '0);
        // one axis moving alone: -y, then -z, then +y
        add_row(mk(10'd2, 10'd2, 10'd2, 4'd2, 32'h00C00000, 32'h00C00000, 32'h00C00000,
                   32'd0, -32'sd65536, 32'd0, 48'd10, 48'd10), 1'b0, '0);
        add_row(mk(10'd2, 10'd2, 10'd2, 4'd2, 32'h00C00000, 32'h00C00000, 32'h00C00000,
                   32'd0, 32'd0, -32'sd65536, 48'd10, 48'd10), 1'b0, '0);
        add_row(mk(10'd2, 10'd2, 10'd2, 4'd2, 32'h00C00000, 32'h00C00000, 32'h00C00000,
                   32'd0, 32'd65536, 32'd0, 48'd10, 48'd10), 1'b0, '0);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[r])
            send_particle(dir_rows[r].stim, dir_rows[r].has_exp, dir_rows[r].exp);
        drain();

        // zero cell side: every wall at zero
        reg_write(31'd1);
        send_particle(mk(10'd3, 10'd0, 10'd0, 4'd10, 32'd5, -32'sd5, 32'd0, 32'd65536,
                         -32'sd65536, 32'd1, 48'd1, 48'd0), 1'b0, '0);
        random_burst(60);
        drain();

        reg_write(31'h7FFFFFFF);
        random_burst(200);
        drain();

        reg_write(31'd655360);
        random_burst(200);
        drain();

        reg_write(31'($urandom));
        random_burst(190);
        drain();

        if (errors == 0)
            $display("PASS grid_cell_exit_time_unit");
        else
            $display("FAIL grid_cell_exit_time_unit");
        $finish;
    end

endmodule
